@@ rtl/ltmg_pkg.sv @@
// Shared constants, colour tables and curve-building functions for the
// luminance tone map and grade block. No dependencies.
`timescale 1ns / 1ps
package ltmg_pkg;

  localparam int MAX_DIM_DEF    = 4096;
  localparam int TABLE_BITS_DEF = 10;

  // configuration register indexes
  localparam logic [7:0] REG_EXPOSURE   = 8'd0;
  localparam logic [7:0] REG_INV_WIDTH  = 8'd1;
  localparam logic [7:0] REG_INV_HEIGHT = 8'd2;
  localparam logic [7:0] REG_INV_SPAN   = 8'd3;

  localparam logic [31:0] EXPOSURE_RST  = 32'd65536;
  localparam logic [23:0] INV_WIDTH_RST = 24'd4096;
  localparam logic [23:0] INV_HEIGHT_RST = 24'd4096;
  localparam logic [23:0] INV_SPAN_RST  = 24'd4097;

  localparam logic [16:0] ONE16      = 17'd65536;
  localparam logic [24:0] ONE24      = 25'd16777216;
  localparam logic [63:0] LN2_Q32    = 64'd2977044472;
  localparam logic [63:0] LOG2E_Q30  = 64'd1549082005;
  localparam logic [16:0] BLEND_E0   = 17'd983;
  localparam logic [16:0] BLEND_SPAN = 17'd6881;
  localparam logic [16:0] KNEE       = 17'd38011;
  localparam logic [16:0] HOT_SPAN   = 17'd27525;
  localparam logic [13:0] VIG_GAIN   = 14'd10486;
  localparam logic [15:0] NY_WEIGHT  = 16'd52429;

  // floor(2^32 / span) for the smoothstep quotient
  localparam logic [23:0] REC_BLEND = 24'((64'd1 << 32) / 64'd6881);
  localparam logic [23:0] REC_KNEE  = 24'((64'd1 << 32) / 64'd38011);
  localparam logic [23:0] REC_HOT   = 24'((64'd1 << 32) / 64'd27525);

  typedef logic [16:0] rgb_t [3];

  localparam rgb_t SHADOW_C  = '{17'd3932,  17'd5243,  17'd7864};
  localparam rgb_t MID_C     = '{17'd30802, 17'd35389, 17'd44564};
  localparam rgb_t HOT_C     = '{17'd65536, 17'd58982, 17'd49152};
  localparam rgb_t HORIZON_C = '{17'd2294,  17'd2490,  17'd3277};
  localparam rgb_t ZENITH_C  = '{17'd655,   17'd983,   17'd1966};

  // exp(-a), a in Q0.32 below ln 2, result Q0.32 (elaboration only)
  function automatic logic [63:0] exp_neg_q32(logic [63:0] a);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * a) >> 32) / 64'(n);
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  // 2^-w, w in Q8.24, result Q0.32
  function automatic logic [63:0] pow2_neg(logic [63:0] w);
    logic [63:0] ip;
    logic [63:0] fp;
    ip = w >> 24;
    fp = w & 64'hFFFFFF;
    if (ip >= 64'd32) return 64'd0;
    return exp_neg_q32((fp * LN2_Q32) >> 24) >> ip;
  endfunction

  function automatic logic [16:0] map_entry(int tb, int k);
    logic [63:0] w;
    logic [63:0] g;
    w = ((64'(k) << (28 - tb)) * LOG2E_Q30) >> 30;
    g = (pow2_neg(w) + 64'h8000) >> 16;
    return 17'(64'd65536 - g);
  endfunction

  function automatic logic [16:0] pow_entry(int tb, int k);
    logic [63:0] m;
    logic [63:0] lg;
    logic [63:0] w;
    logic [31:0] frac;
    int p;
    p = 0;
    frac = 32'd0;
    if (k == 0) return 17'd0;
    for (int i = 0; i < 31; i++) begin
      if ((k >> (i + 1)) != 0) p = i + 1;
    end
    m = 64'(k) << (30 - p);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 32'd1;
      end
    end
    lg = (64'(tb) << 24) - ((64'(p) << 24) | 64'(frac));
    w = (lg * 64'd9) / 64'd10;
    return 17'((pow2_neg(w) + 64'h8000) >> 16);
  endfunction

endpackage

@@ rtl/ltmg_smooth.sv @@
// Pipelined smoothstep: quotient by reciprocal with one correction, then
// t*t*(3-2t). Four register stages. Depends on ltmg_pkg.
`timescale 1ns / 1ps
module ltmg_smooth import ltmg_pkg::*; (
  input  logic        clk,
  input  logic [16:0] x,
  input  logic [16:0] e0,
  input  logic [16:0] span,
  input  logic [23:0] recip,
  output logic [16:0] s
);

  logic [16:0] a;
  logic [39:0] qa;
  logic [15:0] a_r;
  logic [16:0] q0_r;
  logic [16:0] span_r;
  logic        zero_r;
  logic        full_r;
  logic [33:0] rem;
  logic [16:0] t_nxt;
  logic [16:0] t_r;
  logic [16:0] tc_r;
  logic [33:0] tt_r;
  logic [17:0] cub;
  logic [51:0] prod;
  logic [16:0] s_r;

  assign a  = x - e0;
  assign qa = 40'(a[15:0]) * 40'(recip);

  always_ff @(posedge clk) begin
    a_r    <= a[15:0];
    q0_r   <= qa[32:16];
    span_r <= span;
    zero_r <= (x <= e0);
    full_r <= (x > e0) && (a >= span);
  end

  // q0 is the quotient or one short of it
  always_comb begin
    rem = {2'b00, a_r, 16'd0} - 34'(q0_r) * 34'(span_r);
    if (zero_r) t_nxt = 17'd0;
    else if (full_r) t_nxt = ONE16;
    else if (rem >= 34'(span_r)) t_nxt = q0_r + 17'd1;
    else t_nxt = q0_r;
  end

  always_ff @(posedge clk) begin
    t_r  <= t_nxt;
    tt_r <= 34'(t_r) * 34'(t_r);
    tc_r <= t_r;
    s_r  <= prod[48:32];
  end

  assign cub  = 18'd196608 - {tc_r, 1'b0};
  assign prod = 52'(tt_r) * 52'(cub);
  assign s    = s_r;

endmodule

@@ rtl/luminance_tone_map_grade.sv @@
// Top level of the luminance tone map and colour grade pipeline.
// Depends on ltmg_pkg and ltmg_smooth.
`timescale 1ns / 1ps
// Usage:
//   Pixel words enter on start with in_pixel_x, in_pixel_y, in_luminance.
//   busy is always low: a word may enter on every clock.
//   Each word gives one RGB word on out_red/out_green/out_blue with
//   out_valid high for one cycle at the end of the pipeline.
//   Throughput is one pixel per clock; the depth is set by the two
//   curve lookups (registered table reads plus interpolation) and the
//   four-stage smoothstep units feeding the blend multipliers.
//   Registers: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Index 0 exposure, 1 inv_width, 2 inv_height,
//   3 inv_row_span; other indexes are dropped. Write only when idle.
//   Reset (rst_n low at a clock edge) empties the pipeline and restores
//   the register defaults. The receiver cannot stall the output: every
//   result is shown for exactly one cycle.
module luminance_tone_map_grade import ltmg_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] in_pixel_x,
  input  logic [11:0] in_pixel_y,
  input  logic [31:0] in_luminance,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int TBL_N  = 1 << TABLE_BITS;
  localparam int MAP_FB = 20 - TABLE_BITS;
  localparam int POW_FB = 16 - TABLE_BITS;
  localparam int MAP_W  = 17 + MAP_FB;
  localparam int POW_W  = 17 + POW_FB;
  localparam int DEPTH  = 12;
  localparam logic [16:0] DIM_LIM = 17'(MAX_DIM - 1);

  typedef logic [16:0] tab_t [TBL_N + 1];

  function automatic tab_t build_map();
    tab_t t;
    for (int k = 0; k <= TBL_N; k++) t[k] = map_entry(TABLE_BITS, k);
    return t;
  endfunction

  function automatic tab_t build_pow();
    tab_t t;
    for (int k = 0; k <= TBL_N; k++) t[k] = pow_entry(TABLE_BITS, k);
    return t;
  endfunction

  localparam tab_t MAP_TAB = build_map();
  localparam tab_t POW_TAB = build_pow();

  function automatic logic [16:0] mix(logic [16:0] a, logic [16:0] b, logic [16:0] s);
    logic [34:0] acc;
    acc = 35'(a) * 35'(ONE16 - s) + 35'(b) * 35'(s) + 35'd32768;
    return acc[32:16];
  endfunction

  function automatic logic [24:0] centre_dist(logic [36:0] u);
    logic [36:0] d;
    d = (u >= 37'(ONE24)) ? u - 37'(ONE24) : 37'(ONE24) - u;
    return (d > 37'(ONE24)) ? ONE24 : d[24:0];
  endfunction

  // configuration registers
  logic [31:0] exposure_r;
  logic [23:0] inv_width_r;
  logic [23:0] inv_height_r;
  logic [23:0] inv_span_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exposure_r   <= EXPOSURE_RST;
      inv_width_r  <= INV_WIDTH_RST;
      inv_height_r <= INV_HEIGHT_RST;
      inv_span_r   <= INV_SPAN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXPOSURE:   exposure_r   <= cfg_data;
        REG_INV_WIDTH:  inv_width_r  <= cfg_data[23:0];
        REG_INV_HEIGHT: inv_height_r <= cfg_data[23:0];
        REG_INV_SPAN:   inv_span_r   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // valid bits travel beside the data
  logic [DEPTH:1] vld_r;
  logic [DEPTH:1] vld_nxt;

  assign vld_nxt = {vld_r[DEPTH-1:1], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= vld_nxt;
  end

  // stage 1: exposure product, row and centre products
  logic [11:0] xs;
  logic [11:0] ys;
  logic [63:0] lum_prod;
  logic [31:0] p_r;
  logic [35:0] ys_r;
  logic [36:0] ux_r;
  logic [36:0] uy_r;

  assign xs = ({5'd0, in_pixel_x} > DIM_LIM) ? DIM_LIM[11:0] : in_pixel_x;
  assign ys = ({5'd0, in_pixel_y} > DIM_LIM) ? DIM_LIM[11:0] : in_pixel_y;
  assign lum_prod = 64'(in_luminance) * 64'(exposure_r);

  always_ff @(posedge clk) begin
    p_r  <= (lum_prod[63:48] != 16'd0) ? 32'hFFFF_FFFF : lum_prod[47:16];
    ys_r <= 36'(ys) * 36'(inv_span_r);
    ux_r <= 37'({xs, 1'b1}) * 37'(inv_width_r);
    uy_r <= 37'({ys, 1'b1}) * 37'(inv_height_r);
  end

  // stage 2: exposure table read, gradient, centre distances
  logic [TABLE_BITS:0]   map_idx;
  logic [16:0]           map_a_r;
  logic [16:0]           map_b_r;
  logic [MAP_FB-1:0]     map_fr_r;
  logic                  map_sat_r;
  logic [24:0]           ysc;
  logic [24:0]           vsum;
  logic [16:0]           v_r;
  logic [24:0]           nx_r;
  logic [24:0]           ny_r;

  assign map_idx = {1'b0, p_r[19:MAP_FB]};
  assign ysc     = (ys_r > 36'(ONE24)) ? ONE24 : ys_r[24:0];
  assign vsum    = ONE24 - ysc + 25'd128;

  always_ff @(posedge clk) begin
    map_a_r   <= MAP_TAB[map_idx];
    map_b_r   <= MAP_TAB[map_idx + 1'b1];
    map_fr_r  <= p_r[MAP_FB-1:0];
    map_sat_r <= (p_r[31:20] != 12'd0);
    v_r       <= vsum[24:8];
    nx_r      <= centre_dist(ux_r);
    ny_r      <= centre_dist(uy_r);
  end

  // stage 3: exposure interpolation, squares, background colour
  logic [16:0]      map_diff;
  logic [MAP_W-1:0] map_step;
  logic [16:0]      mapped_r;
  logic [49:0]      nx_sq;
  logic [49:0]      ny_sq;
  logic [25:0]      nx2_r;
  logic [25:0]      ny2_r;
  logic [16:0]      bg_r [3];

  assign map_diff = (map_b_r > map_a_r) ? map_b_r - map_a_r : 17'd0;
  assign map_step = (MAP_W'(map_diff) * MAP_W'(map_fr_r)) >> MAP_FB;
  assign nx_sq    = 50'(nx_r) * 50'(nx_r);
  assign ny_sq    = 50'(ny_r) * 50'(ny_r);

  always_ff @(posedge clk) begin
    mapped_r <= map_sat_r ? MAP_TAB[TBL_N] : map_a_r + map_step[16:0];
    nx2_r    <= nx_sq[49:24];
    ny2_r    <= ny_sq[49:24];
    for (int c = 0; c < 3; c++) bg_r[c] <= mix(HORIZON_C[c], ZENITH_C[c], v_r);
  end

  // stage 4: power table read, vignette radius
  logic [TABLE_BITS:0] pow_idx;
  logic [16:0]         pow_a_r;
  logic [16:0]         pow_b_r;
  logic [POW_FB-1:0]   pow_fr_r;
  logic                pow_sat_r;
  logic [41:0]         ny_w;
  logic [26:0]         rsum;
  logic [24:0]         r_r;
  logic [16:0]         bg4_r [3];

  assign pow_idx = {1'b0, mapped_r[15:POW_FB]};
  assign ny_w    = 42'(ny2_r) * 42'(NY_WEIGHT);
  assign rsum    = 27'(nx2_r) + 27'(ny_w[41:16]);

  always_ff @(posedge clk) begin
    pow_a_r   <= POW_TAB[pow_idx];
    pow_b_r   <= POW_TAB[pow_idx + 1'b1];
    pow_fr_r  <= mapped_r[POW_FB-1:0];
    pow_sat_r <= mapped_r[16];
    r_r       <= (rsum > 27'(ONE24)) ? ONE24 : rsum[24:0];
    bg4_r     <= bg_r;
  end

  // stage 5: power interpolation, vignette gain
  logic [16:0]      pow_diff;
  logic [POW_W-1:0] pow_step;
  logic [16:0]      graded_r;
  logic [39:0]      vig_prod;
  logic [16:0]      vig_r;
  logic [16:0]      bg5_r [3];

  assign pow_diff = (pow_b_r > pow_a_r) ? pow_b_r - pow_a_r : 17'd0;
  assign pow_step = (POW_W'(pow_diff) * POW_W'(pow_fr_r)) >> POW_FB;
  assign vig_prod = 40'(r_r) * 40'(VIG_GAIN) + 40'd8388608;

  always_ff @(posedge clk) begin
    graded_r <= pow_sat_r ? POW_TAB[TBL_N] : pow_a_r + pow_step[16:0];
    vig_r    <= ONE16 - 17'(vig_prod[39:24]);
    bg5_r    <= bg4_r;
  end

  // stages 6..9: two smoothstep units; grade segment picked at the knee
  logic [16:0] tg;
  logic        knee_sel;
  logic [16:0] g_e0;
  logic [16:0] g_span;
  logic [23:0] g_rec;
  logic [16:0] blend_s;
  logic [16:0] grade_s;

  assign tg       = (graded_r > ONE16) ? ONE16 : graded_r;
  assign knee_sel = (tg >= KNEE);
  assign g_e0     = knee_sel ? KNEE : 17'd0;
  assign g_span   = knee_sel ? HOT_SPAN : KNEE;
  assign g_rec    = knee_sel ? REC_HOT : REC_KNEE;

  ltmg_smooth u_blend (
    .clk   (clk),
    .x     (graded_r),
    .e0    (BLEND_E0),
    .span  (BLEND_SPAN),
    .recip (REC_BLEND),
    .s     (blend_s)
  );

  ltmg_smooth u_grade (
    .clk   (clk),
    .x     (tg),
    .e0    (g_e0),
    .span  (g_span),
    .recip (g_rec),
    .s     (grade_s)
  );

  // dimmed background and knee flag held beside the smoothstep units
  logic [33:0] bgv_prod [3];
  logic [16:0] bgv_d_r [5][3];
  logic        knee_d_r [4];

  always_comb begin
    for (int c = 0; c < 3; c++) bgv_prod[c] = 34'(bg5_r[c]) * 34'(vig_r) + 34'd32768;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) bgv_d_r[0][c] <= bgv_prod[c][32:16];
    for (int i = 1; i < 5; i++) bgv_d_r[i] <= bgv_d_r[i-1];
    knee_d_r[0] <= knee_sel;
    for (int i = 1; i < 4; i++) knee_d_r[i] <= knee_d_r[i-1];
  end

  // stage 10: grade colour
  logic [16:0] fg_r [3];
  logic [16:0] blend_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (knee_d_r[3]) fg_r[c] <= mix(MID_C[c], HOT_C[c], grade_s);
      else fg_r[c] <= mix(SHADOW_C[c], MID_C[c], grade_s);
    end
    blend_r <= blend_s;
  end

  // stage 11: blend over background
  logic [16:0] col_r [3];

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) col_r[c] <= mix(bgv_d_r[4][c], fg_r[c], blend_r);
  end

  // stage 12: scale to 8 bits and clamp
  logic [24:0] q [3];
  logic [7:0]  q8 [3];
  logic [7:0]  rgb_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q[c]  = 25'(col_r[c]) * 25'd255;
      q8[c] = (q[c][24:16] > 9'd255) ? 8'd255 : q[c][23:16];
    end
  end

  always_ff @(posedge clk) begin
    rgb_r <= q8;
  end

  assign out_valid = vld_r[DEPTH];
  assign out_red   = rgb_r[0];
  assign out_green = rgb_r[1];
  assign out_blue  = rgb_r[2];

endmodule

@@ tb/sv/ltmg_grade_checker.sv @@
// Checker for the luminance tone map and grade block: watches the pixel, result
// and register channels, predicts each RGB word and compares. Depends on ltmg_pkg.
`timescale 1ns / 1ps
module ltmg_grade_checker import ltmg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [11:0] in_pixel_x,
  input  logic [11:0] in_pixel_y,
  input  logic [31:0] in_luminance,
  input  logic        out_valid,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int CURVE_N = 1 << TABLE_BITS_DEF;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_word_t;

  logic [31:0] exp_gain;
  logic [23:0] inv_w;
  logic [23:0] inv_h;
  logic [23:0] inv_span;
  logic [63:0] exp_curve [0:CURVE_N];
  logic [63:0] gamma_curve [0:CURVE_N];
  rgb_word_t   rgb_expected [$];

  function automatic logic [63:0] decay_q32(logic [63:0] a);
    logic [63:0] acc;
    logic [63:0] term;
    acc  = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * a) >> 32) / n;
      if (n % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    return acc;
  endfunction

  function automatic logic [63:0] exp2_neg(logic [63:0] w);
    if ((w >> 24) >= 64'd32) return 64'd0;
    return decay_q32(((w & 64'hFFFFFF) * 64'd2977044472) >> 24) >> (w >> 24);
  endfunction

  function automatic logic [63:0] curve_lerp(logic [63:0] tab [0:CURVE_N], logic [63:0] pos,
                                             int fb);
    logic [63:0] idx;
    logic [63:0] fr;
    idx = pos >> fb;
    fr  = pos & ((64'd1 << fb) - 1);
    if (idx >= CURVE_N) return tab[CURVE_N];
    if (tab[idx + 1] <= tab[idx]) return tab[idx];
    return tab[idx] + (((tab[idx + 1] - tab[idx]) * fr) >> fb);
  endfunction

  function automatic logic [63:0] ease(logic [63:0] x, logic [63:0] e0, logic [63:0] span);
    logic [63:0] t;
    if (x <= e0) return 64'd0;
    t = ((x - e0) << 16) / span;
    if (t > 64'd65536) t = 64'd65536;
    return (t * t * (64'd196608 - 2 * t)) >> 32;
  endfunction

  function automatic logic [63:0] lerp16(logic [63:0] a, logic [63:0] b, logic [63:0] s);
    return (a * (64'd65536 - s) + b * s + 64'd32768) >> 16;
  endfunction

  function automatic logic [63:0] off_centre(logic [63:0] c, logic [63:0] inv);
    logic [63:0] u;
    logic [63:0] d;
    u = (2 * c + 1) * inv;
    d = (u >= 64'd16777216) ? u - 64'd16777216 : 64'd16777216 - u;
    return (d > 64'd16777216) ? 64'd16777216 : d;
  endfunction

  function automatic rgb_word_t predict_rgb(logic [11:0] px, logic [11:0] py,
                                            logic [31:0] lum);
    logic [63:0] x, y, p, mapped, graded, blend, ys, v, nx, ny, r, vig, t;
    logic [63:0] bg, fg, col, q;
    logic [7:0] ch [3];
    rgb_word_t res;
    x = px;
    y = py;
    if (x >= MAX_DIM_DEF) x = MAX_DIM_DEF - 1;
    if (y >= MAX_DIM_DEF) y = MAX_DIM_DEF - 1;
    p = (64'(lum) * exp_gain) >> 16;
    if (p > 64'hFFFFFFFF) p = 64'hFFFFFFFF;
    mapped = (p >= (64'd1 << 20)) ? exp_curve[CURVE_N]
           : curve_lerp(exp_curve, p, 20 - TABLE_BITS_DEF);
    graded = (mapped >= 64'd65536) ? gamma_curve[CURVE_N]
           : curve_lerp(gamma_curve, mapped, 16 - TABLE_BITS_DEF);
    blend = ease(graded, 64'd983, 64'd6881);
    ys = y * inv_span;
    if (ys > 64'd16777216) ys = 64'd16777216;
    v = (64'd16777216 - ys + 64'd128) >> 8;
    nx = off_centre(x, inv_w);
    ny = off_centre(y, inv_h);
    r = ((nx * nx) >> 24) + ((((ny * ny) >> 24) * 64'd52429) >> 16);
    if (r > 64'd16777216) r = 64'd16777216;
    vig = 64'd65536 - ((r * 64'd10486 + (64'd1 << 23)) >> 24);
    t = (graded > 64'd65536) ? 64'd65536 : graded;
    for (int c = 0; c < 3; c++) begin
      bg = lerp16(HORIZON_C[c], ZENITH_C[c], v);
      bg = (bg * vig + 64'd32768) >> 16;
      if (t < 64'd38011) fg = lerp16(SHADOW_C[c], MID_C[c], ease(t, 64'd0, 64'd38011));
      else fg = lerp16(MID_C[c], HOT_C[c], ease(t, 64'd38011, 64'd27525));
      col = lerp16(bg, fg, blend);
      q = (col * 255) >> 16;
      ch[c] = (q > 255) ? 8'd255 : q[7:0];
    end
    res.red   = ch[0];
    res.green = ch[1];
    res.blue  = ch[2];
    return res;
  endfunction

  initial begin
    logic [63:0] w, m, lg;
    logic [31:0] frac;
    int p;
    for (int k = 0; k <= CURVE_N; k++) begin
      w = ((64'(k) << (28 - TABLE_BITS_DEF)) * 64'd1549082005) >> 30;
      exp_curve[k] = 64'd65536 - ((exp2_neg(w) + 64'h8000) >> 16);
    end
    gamma_curve[0] = 64'd0;
    for (int k = 1; k <= CURVE_N; k++) begin
      p = 0;
      frac = 32'd0;
      while ((k >> (p + 1)) != 0) p++;
      m = 64'(k) << (30 - p);
      // square and renormalize to pull out one log2 bit per pass
      for (int i = 0; i < 24; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          frac = frac | 32'd1;
        end
      end
      lg = (64'(TABLE_BITS_DEF) << 24) - ((64'(p) << 24) | 64'(frac));
      gamma_curve[k] = (exp2_neg((lg * 9) / 10) + 64'h8000) >> 16;
    end
  end

  always @(posedge clk) begin
    rgb_word_t want;
    if (!rst_n) begin
      exp_gain   <= EXPOSURE_RST;
      inv_w      <= INV_WIDTH_RST;
      inv_h      <= INV_HEIGHT_RST;
      inv_span   <= INV_SPAN_RST;
      rgb_expected.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (out_valid) begin
        if (rgb_expected.size() == 0) begin
          $error("unexpected word: red %0d green %0d blue %0d", out_red, out_green, out_blue);
          fail_count <= fail_count + 1;
        end else begin
          want = rgb_expected.pop_front();
          if (out_red !== want.red || out_green !== want.green || out_blue !== want.blue)
            fail_count <= fail_count + 1;
          if (out_red !== want.red)
            $error("red: expected %0d actual %0d", want.red, out_red);
          if (out_green !== want.green)
            $error("green: expected %0d actual %0d", want.green, out_green);
          if (out_blue !== want.blue)
            $error("blue: expected %0d actual %0d", want.blue, out_blue);
        end
      end
      if (start && !busy)
        rgb_expected.push_back(predict_rgb(in_pixel_x, in_pixel_y, in_luminance));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EXPOSURE:   exp_gain <= cfg_data;
          REG_INV_WIDTH:  inv_w    <= cfg_data[23:0];
          REG_INV_HEIGHT: inv_h    <= cfg_data[23:0];
          REG_INV_SPAN:   inv_span <= cfg_data[23:0];
          default: ;
        endcase
      end
      pending <= rgb_expected.size();
    end
  end

endmodule

@@ tb/sv/tb_luminance_tone_map_grade.sv @@
// Testbench top for luminance_tone_map_grade: clock, reset, pixel and register
// stimulus, watchdog and verdict. Depends on ltmg_pkg and ltmg_grade_checker.
`timescale 1ns / 1ps
module tb_luminance_tone_map_grade;
  import ltmg_pkg::*;

  localparam logic [7:0] REG_NONE_LOW  = 8'd4;
  localparam logic [7:0] REG_NONE_HIGH = 8'd255;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [11:0] in_pixel_x = '0;
  logic [11:0] in_pixel_y = '0;
  logic [31:0] in_luminance = '0;
  logic        out_valid;
  logic [7:0]  out_red, out_green, out_blue;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          quiet_cycles = 0;
  bit          allow_gaps = 1'b1;

  always #5 clk = ~clk;

  luminance_tone_map_grade dut (.*);

  ltmg_grade_checker checker_i (.*);

  // watchdog: any accepted word, output word or reset clears the count
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      quiet_cycles <= 0;
    else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic send_pixel(logic [11:0] x, logic [11:0] y, logic [31:0] lum);
    start        <= 1'b1;
    in_pixel_x   <= x;
    in_pixel_y   <= y;
    in_luminance <= lum;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (allow_gaps && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (allow_gaps && $urandom_range(0, 1) == 0)
      repeat ($urandom_range(1, 11)) @(posedge clk);
  endtask

  task automatic set_frame(logic [31:0] gain, logic [23:0] iw, logic [23:0] ih,
                           logic [23:0] span);
    drain();
    write_reg(REG_EXPOSURE, gain);
    write_reg(REG_INV_WIDTH, {8'd0, iw});
    write_reg(REG_INV_HEIGHT, {8'd0, ih});
    write_reg(REG_INV_SPAN, {8'd0, span});
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_lum();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  task automatic random_frame(int count);
    int w, h;
    w = $urandom_range(2, 4096);
    h = $urandom_range(2, 4096);
    set_frame(random_lum(), 24'((1 << 24) / w), 24'((1 << 24) / h), 24'((1 << 24) / (h - 1)));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_pixel(12'($urandom), 12'($urandom), $urandom);
      else
        send_pixel(12'($urandom_range(0, w - 1)), 12'($urandom_range(0, h - 1)),
                   random_lum());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values first
    send_pixel(12'd0, 12'd0, 32'd0);
    send_pixel(12'd4095, 12'd4095, 32'hFFFFFFFF);
    send_pixel(12'd2048, 12'd2048, 32'h000FFFFF);
    send_pixel(12'd2047, 12'd0, 32'h00100000);
    send_pixel(12'd0, 12'd4095, 32'h00000001);
    send_pixel(12'd1234, 12'd3000, 32'h0000E000);
    send_pixel(12'd100, 12'd200, 32'h00002000);
    send_pixel(12'd4000, 12'd17, 32'h00010000);

    // dropped indexes, then saturating extremes
    drain();
    write_reg(REG_NONE_LOW, 32'hFFFFFFFF);
    write_reg(REG_NONE_HIGH, 32'h0);
    set_frame(32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_pixel(12'd0, 12'd0, 32'h00000001);
    send_pixel(12'd4095, 12'd4095, 32'hFFFFFFFF);
    send_pixel(12'd1, 12'd2, 32'h0);
    send_pixel(12'hAAA, 12'h555, 32'h00000100);

    set_frame(32'd0, 24'd0, 24'd0, 24'd0);
    send_pixel(12'd4095, 12'd0, 32'hFFFFFFFF);
    send_pixel(12'd0, 12'd4095, 32'h12345678);
    send_pixel(12'h555, 12'hAAA, 32'h0);

    set_frame(32'h00000001, 24'd4096, 24'd6991, 24'd6997);
    send_pixel(12'd2047, 12'd1199, 32'hFFFFFFFF);
    send_pixel(12'd0, 12'd0, 32'h00800000);

    for (int f = 0; f < 7; f++) random_frame(240);

    // final stretch runs back to back
    allow_gaps = 1'b0;
    random_frame(220);
    set_frame(EXPOSURE_RST, INV_WIDTH_RST, INV_HEIGHT_RST, INV_SPAN_RST);
    for (int i = 0; i < 20; i++) send_pixel(12'($urandom), 12'($urandom), random_lum());

    drain();
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
